>>> rtl/core/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and constants of the round-robin run queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

  localparam int TID_W       = 4;
  localparam int NUM_IDS     = 16;
  localparam int SLICE_W     = 16;
  localparam int OP_W        = 3;
  localparam int ST_W        = 2;
  localparam int OUT_CNT_W   = 5;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd100;

  localparam logic [OP_W-1:0] OP_ENQ   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQ   = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd2;
  localparam logic [OP_W-1:0] OP_YIELD = 3'd3;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP    = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;

  typedef struct packed {
    logic            load;
    logic            set_flags;
    logic [ST_W-1:0] flag_status;
    logic            flag_resched;
    logic            slice_reload;
    logic            slice_dec;
    logic            member_set;
    logic            member_clr;
    logic            scan_init;
    logic            shift_init;
    logic            scan_step;
    logic            shift_step;
    logic            wr_tail_new;
    logic            wr_tail_move;
    logic            wr_head;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            rd_head;
    logic            out_load;
  } rrq_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            tid_ok;
    logic            hit;
    logic            full;
    logic            cnt_gt1;
    logic            slice_le1;
    logic            at_head;
    logic            wakeup;
    logic            walk_done;
    logic            out_busy;
  } rrq_stat_t;

endpackage

>>> rtl/core/rrq_ctrl.sv
// ----------------------------------------------------------------------------
// rrq_ctrl
// Controller of the run queue: decodes each word and sequences the datapath.
// ----------------------------------------------------------------------------
module rrq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  rrq_pkg::rrq_stat_t stat,
  output rrq_pkg::rrq_cmd_t  cmd
);
  import rrq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_HEADRD = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.set_flags = 1'b1;
        cmd.flag_status = ST_OK;
        state_next = S_HEADRD;
        if (stat.op inside {OP_ENQ, OP_DEQ, OP_TICK, OP_YIELD}) begin
          if (!stat.tid_ok) begin
            cmd.flag_status = ST_ABSENT;
          end else if (stat.op == OP_ENQ) begin
            if (stat.hit || stat.full) begin
              cmd.flag_status = ST_DUP;
            end else begin
              cmd.slice_reload = stat.wakeup;
              cmd.member_set   = 1'b1;
              if (stat.at_head) begin
                cmd.shift_init = 1'b1;
                state_next     = S_SHIFT;
              end else begin
                cmd.wr_tail_new = 1'b1;
                cmd.cnt_inc     = 1'b1;
              end
            end
          end else if (!stat.hit) begin
            cmd.flag_status = ST_ABSENT;
          end else if (stat.op == OP_DEQ) begin
            cmd.member_clr = 1'b1;
            cmd.scan_init  = 1'b1;
            state_next     = S_SCAN;
          end else if (stat.op == OP_YIELD) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end else if (stat.slice_le1) begin
            cmd.slice_reload = 1'b1;
            if (stat.cnt_gt1) begin
              cmd.flag_resched = 1'b1;
              cmd.scan_init    = 1'b1;
              state_next       = S_SCAN;
            end
          end else begin
            cmd.slice_dec = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (stat.walk_done) begin
          if (stat.op == OP_DEQ) begin
            cmd.cnt_dec = 1'b1;
          end else begin
            cmd.wr_tail_move = 1'b1;
          end
          state_next = S_HEADRD;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.walk_done) begin
          cmd.wr_head = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_HEADRD;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_HEADRD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/rrq_datapath.sv
// ----------------------------------------------------------------------------
// rrq_datapath
// Queue order memory, membership, slice counters and the result register.
// ----------------------------------------------------------------------------
module rrq_datapath #(
  parameter int MAX_TASKS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [rrq_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [rrq_pkg::OP_W-1:0]          s_tuser,
  input  logic                              cfg_wr_en,
  input  logic [rrq_pkg::SLICE_W-1:0]       cfg_wr_data,
  input  rrq_pkg::rrq_cmd_t                 cmd,
  output rrq_pkg::rrq_stat_t                stat,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rrq_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import rrq_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic [TID_W-1:0]   order_mem [MAX_TASKS];
  logic [TID_W-1:0]   rd_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [TID_W-1:0]   wr_data;

  logic [SLICE_W-1:0] slice_ticks;
  logic [SLICE_W-1:0] slice_left [NUM_IDS];
  logic [NUM_IDS-1:0] member_bits;
  logic [CNT_W-1:0]   task_count;

  logic [OP_W-1:0]    op;
  logic [TID_W-1:0]   tid;
  logic               at_head;
  logic               wakeup;
  logic [ST_W-1:0]    status;
  logic               resched;

  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   pidx;
  logic               run;
  logic               pv;
  logic               found;
  logic               issue;
  logic [IDX_W-1:0]   count_idx;
  logic [IDX_W-1:0]   count_m1;
  logic               head_valid;

  assign count_idx = IDX_W'(task_count);
  assign count_m1  = IDX_W'(task_count - 1'b1);
  assign issue     = (cmd.scan_step || cmd.shift_step) && run;
  assign rd_en     = issue || cmd.rd_head;
  assign rd_addr   = cmd.rd_head ? '0 : ptr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = tid;
    if (cmd.scan_step && pv && found) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(pidx - 1'b1);
      wr_data = rd_data;
    end else if (cmd.shift_step && pv) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(pidx + 1'b1);
      wr_data = rd_data;
    end else if (cmd.wr_tail_new) begin
      wr_en   = 1'b1;
      wr_addr = count_idx;
    end else if (cmd.wr_tail_move) begin
      wr_en   = 1'b1;
      wr_addr = count_m1;
    end else if (cmd.wr_head) begin
      wr_en   = 1'b1;
      wr_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      order_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= order_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    pv <= issue;
    if (cmd.scan_init) begin
      ptr   <= '0;
      run   <= 1'b1;
      found <= 1'b0;
    end else if (cmd.shift_init) begin
      ptr   <= count_m1;
      run   <= (task_count != '0);
      found <= 1'b0;
    end else begin
      if (cmd.scan_step && pv && !found && (rd_data == tid)) begin
        found <= 1'b1;
      end
      if (issue) begin
        pidx <= ptr;
        if (cmd.scan_step) begin
          if (ptr == count_m1) begin
            run <= 1'b0;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end else begin
          if (ptr == '0) begin
            run <= 1'b0;
          end else begin
            ptr <= ptr - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= s_tuser;
      tid     <= s_tdata[TID_W-1:0];
      at_head <= s_tdata[TID_W];
      wakeup  <= s_tdata[TID_W+1];
    end
    if (cmd.set_flags) begin
      status  <= cmd.flag_status;
      resched <= cmd.flag_resched;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_ticks <= SLICE_RESET;
      member_bits <= '0;
      task_count  <= '0;
      for (int i = 0; i < NUM_IDS; i++) begin
        slice_left[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        slice_ticks <= cfg_wr_data;
      end
      if (cmd.member_set) begin
        member_bits[tid] <= 1'b1;
      end else if (cmd.member_clr) begin
        member_bits[tid] <= 1'b0;
      end
      if (cmd.cnt_inc) begin
        task_count <= task_count + 1'b1;
      end else if (cmd.cnt_dec) begin
        task_count <= task_count - 1'b1;
      end
      if (cmd.slice_reload) begin
        slice_left[tid] <= slice_ticks;
      end else if (cmd.slice_dec) begin
        slice_left[tid] <= slice_left[tid] - 1'b1;
      end
    end
  end

  always_comb begin
    stat.op        = op;
    stat.tid_ok    = (int'(tid) < MAX_TASKS);
    stat.hit       = member_bits[tid];
    stat.full      = (int'(task_count) >= MAX_TASKS);
    stat.cnt_gt1   = (task_count > CNT_W'(1));
    stat.slice_le1 = (slice_left[tid] <= SLICE_W'(1));
    stat.at_head   = at_head;
    stat.wakeup    = wakeup;
    stat.walk_done = !run && !pv;
    stat.out_busy  = m_tvalid && !m_tready;
  end

  assign head_valid = (task_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {3'b000, status, resched, OUT_CNT_W'(task_count),
                  head_valid ? rd_data : {TID_W{1'b0}}, head_valid};
    end
  end

endmodule

>>> rtl/core/round_robin_run_queue_top.sv
// ----------------------------------------------------------------------------
// round_robin_run_queue_top
// Round-robin run queue of task numbers with a time slice per task.
// ----------------------------------------------------------------------------
// Each input word is one scheduler operation and returns one result word.
// A dequeue, a yield, a rotating tick and a head enqueue walk the queue order
// memory through its single read and write port, one entry per cycle; a pick,
// a tail enqueue, a tick that does not rotate and any rejected operation do
// not walk. One word is in work at a time. The next word is accepted once the
// result is registered, even while that result waits. A result that still
// waits when the next one is ready holds the controller until it is taken.
module round_robin_run_queue_top #(
  parameter int MAX_TASKS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // task_id[3:0], at_head[4], wakeup[5], zero[7:6]
  input  logic [rrq_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode[2:0]
  input  logic [rrq_pkg::OP_W-1:0]       s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // picked_valid[0], picked_task[4:1], queue_count[9:5], resched[10],
  // status[12:11], zero[15:13]
  output logic [rrq_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_wr_en,
  input  logic [rrq_pkg::SLICE_W-1:0]    cfg_wr_data
);
  import rrq_pkg::*;

  rrq_cmd_t  cmd;
  rrq_stat_t stat;

  rrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrq_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("run queue accepted a word while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (int'(m_tdata[9:5]) <= MAX_TASKS))
    else $error("queue count above capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[9:5] != 5'd0)))
    else $error("picked_valid disagrees with queue count");

  a_resched_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[10]) |-> (m_tdata[12:11] == ST_OK))
    else $error("reschedule flagged on a rejected operation");
`endif

endmodule
